[hw/rtl/sili_pkg.sv]
// Package for sorted_interval_list_intersect: command codes, sweep states,
// and the record passed from the front part to the sweep engine.
// No dependencies.
package sili_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FLUSH
    } sweep_state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [7:0]  ancestry;
        logic [15:0] tag_a;
        logic [15:0] tag_b;
        logic [7:0]  chrom;
    } op_t;

    typedef struct packed {
        logic [15:0] tag_a_res;
        logic [15:0] tag_b_res;
        logic [7:0]  chrom_res;
        logic [8:0]  anc_a;
        logic [8:0]  anc_b;
        logic [31:0] overlap_start;
        logic [31:0] overlap_end;
        logic        last;
    } res_t;

    localparam logic [8:0]  ANC_NONE = 9'h1FF;
    localparam logic [31:0] POS_NONE = 32'hFFFF_FFFF;

endpackage

[hw/rtl/sili_front.sv]
// Front part: accepts items, drops no-ops, and queues them for the engine.
// Depends on sili_pkg.
module sili_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  sili_pkg::op_t   in_op,
    output logic            q_valid,
    output sili_pkg::op_t   q_op,
    input  logic            q_take
);

    localparam int QD = 2;

    sili_pkg::op_t q_mem [QD];
    logic         wr_reg, wr_next;
    logic         rd_reg, rd_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         wen;

    assign full    = (cnt_reg == 2'(QD));
    assign wen     = push && !full && (in_op.cmd != sili_pkg::CMD_NOP);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = wen ? !wr_reg : wr_reg;
        rd_next  = q_take ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(wen) - 2'(q_take);
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            q_mem[wr_reg] <= in_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
        else $error("take from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !wen) |=> cnt_reg == 2'd0)
        else $error("count rose without write");

endmodule

[hw/rtl/sili_engine.sv]
// Sweep engine: interval stores, loads, two-pointer sweep, result queue.
// Depends on sili_pkg.
module sili_engine #(
    parameter int MAX_INTERVALS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sili_pkg::op_t   q_op,
    output logic            q_take,
    output logic            res_valid,
    output sili_pkg::res_t  res,
    input  logic            res_pop
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int OQ = 2;

    logic [71:0] mem_a [MAX_INTERVALS];
    logic [71:0] mem_b [MAX_INTERVALS];
    logic [71:0] rd_a_reg, rd_b_reg;

    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          pend_vld_reg, pend_vld_next;
    logic          hit_neg_reg, hit_neg_next;
    sili_pkg::res_t pend_reg, pend_next;
    logic [15:0]   ta_reg, ta_next, tb_reg, tb_next;
    logic [7:0]    ch_reg, ch_next;
    sili_pkg::sweep_state_t st_reg, st_next;

    sili_pkg::res_t oq [OQ];
    logic           ow_reg, or_reg;
    logic [1:0]     oc_reg;
    logic           emit;
    sili_pkg::res_t emit_res;

    logic signed [31:0] sa, ea, sb, eb;
    logic neg, ovl, more, done;
    logic room;

    assign sa = signed'(rd_a_reg[71:40]);
    assign ea = signed'(rd_a_reg[39:8]);
    assign sb = signed'(rd_b_reg[71:40]);
    assign eb = signed'(rd_b_reg[39:8]);
    assign neg = (sa == -32'sd1) || (ea == -32'sd1) || (sb == -32'sd1) || (eb == -32'sd1);
    assign ovl = (ea >= sb) && (eb >= sa);
    assign more = (i_reg < cnt_a_reg) && (j_reg < cnt_b_reg);
    assign done = (i_next >= cnt_a_reg) || (j_next >= cnt_b_reg);

    // output queue has room for one more
    assign room = (oc_reg != 2'(OQ));

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            sili_pkg::ST_IDLE:
            begin
                if (q_valid && q_op.cmd == sili_pkg::CMD_RUN)
                begin
                    st_next = sili_pkg::ST_READ;
                end
            end
            sili_pkg::ST_READ:
            begin
                st_next = more ? sili_pkg::ST_CMP : sili_pkg::ST_FLUSH;
            end
            sili_pkg::ST_CMP:
            begin
                if (room)
                begin
                    st_next = (neg || done) ? sili_pkg::ST_FLUSH : sili_pkg::ST_READ;
                end
            end
            sili_pkg::ST_FLUSH:
            begin
                if (room && (!pend_vld_reg || !hit_neg_reg)) st_next = sili_pkg::ST_IDLE;
            end
            default: st_next = sili_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take        = 1'b0;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pend_vld_next = pend_vld_reg;
        hit_neg_next  = hit_neg_reg;
        pend_next     = pend_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        ch_next       = ch_reg;
        emit          = 1'b0;
        emit_res.tag_a_res     = ta_reg;
        emit_res.tag_b_res     = tb_reg;
        emit_res.chrom_res     = ch_reg;
        emit_res.anc_a         = sili_pkg::ANC_NONE;
        emit_res.anc_b         = sili_pkg::ANC_NONE;
        emit_res.overlap_start = sili_pkg::POS_NONE;
        emit_res.overlap_end   = sili_pkg::POS_NONE;
        emit_res.last          = 1'b1;
        unique case (st_reg)
            sili_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    if (q_op.cmd == sili_pkg::CMD_LOAD_A && cnt_a_reg < CW'(MAX_INTERVALS))
                        cnt_a_next = cnt_a_reg + 1'b1;
                    if (q_op.cmd == sili_pkg::CMD_LOAD_B && cnt_b_reg < CW'(MAX_INTERVALS))
                        cnt_b_next = cnt_b_reg + 1'b1;
                    if (q_op.cmd == sili_pkg::CMD_RUN)
                    begin
                        i_next        = '0;
                        j_next        = '0;
                        pend_vld_next = 1'b0;
                        hit_neg_next  = 1'b0;
                        ta_next       = q_op.tag_a;
                        tb_next       = q_op.tag_b;
                        ch_next       = q_op.chrom;
                    end
                end
            end
            sili_pkg::ST_READ: ;
            sili_pkg::ST_CMP:
            begin
                // latest overlap is held back until it is known whether it ends the run
                if (room)
                begin
                    if (neg)
                    begin
                        hit_neg_next = 1'b1;
                    end
                    else if (ovl)
                    begin
                        emit                    = pend_vld_reg;
                        emit_res                = pend_reg;
                        pend_next.tag_a_res     = ta_reg;
                        pend_next.tag_b_res     = tb_reg;
                        pend_next.chrom_res     = ch_reg;
                        pend_next.anc_a         = {1'b0, rd_a_reg[7:0]};
                        pend_next.anc_b         = {1'b0, rd_b_reg[7:0]};
                        pend_next.overlap_start = (sa > sb) ? sa : sb;
                        pend_next.overlap_end   = (ea < eb) ? ea : eb;
                        pend_next.last          = 1'b0;
                        pend_vld_next           = 1'b1;
                        if (ea <= eb) i_next = i_reg + 1'b1;
                        else          j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        if (sa < sb) i_next = i_reg + 1'b1;
                        else         j_next = j_reg + 1'b1;
                    end
                end
            end
            sili_pkg::ST_FLUSH:
            begin
                if (room)
                begin
                    emit = 1'b1;
                    if (pend_vld_reg)
                    begin
                        emit_res      = pend_reg;
                        emit_res.last = !hit_neg_reg;
                        pend_vld_next = 1'b0;
                    end
                    if (!pend_vld_reg || !hit_neg_reg)
                    begin
                        cnt_a_next   = '0;
                        cnt_b_next   = '0;
                        hit_neg_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == sili_pkg::ST_IDLE && q_valid)
        begin
            if (q_op.cmd == sili_pkg::CMD_LOAD_A && cnt_a_reg < CW'(MAX_INTERVALS))
                mem_a[cnt_a_reg[AW-1:0]] <= {q_op.start_pos, q_op.end_pos, q_op.ancestry};
            if (q_op.cmd == sili_pkg::CMD_LOAD_B && cnt_b_reg < CW'(MAX_INTERVALS))
                mem_b[cnt_b_reg[AW-1:0]] <= {q_op.start_pos, q_op.end_pos, q_op.ancestry};
        end
        rd_a_reg <= mem_a[i_reg[AW-1:0]];
        rd_b_reg <= mem_b[j_reg[AW-1:0]];
        if (emit)
            oq[ow_reg] <= emit_res;
    end

    assign res_valid = (oc_reg != 2'd0);
    assign res       = oq[or_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= sili_pkg::ST_IDLE;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            pend_vld_reg <= 1'b0;
            hit_neg_reg  <= 1'b0;
            pend_reg     <= '0;
            ta_reg       <= '0;
            tb_reg       <= '0;
            ch_reg       <= '0;
            ow_reg       <= 1'b0;
            or_reg       <= 1'b0;
            oc_reg       <= 2'd0;
        end
        else
        begin
            st_reg       <= st_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            pend_vld_reg <= pend_vld_next;
            hit_neg_reg  <= hit_neg_next;
            pend_reg     <= pend_next;
            ta_reg       <= ta_next;
            tb_reg       <= tb_next;
            ch_reg       <= ch_next;
            ow_reg       <= emit ? !ow_reg : ow_reg;
            or_reg       <= res_pop ? !or_reg : or_reg;
            oc_reg       <= oc_reg + 2'(emit) - 2'(res_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) emit |-> room)
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) res_pop |-> res_valid)
        else $error("pop from empty result queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_res.last) |=> st_reg == sili_pkg::ST_IDLE || st_reg == sili_pkg::ST_FLUSH)
        else $error("sweep continued after final result");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_a_reg <= CW'(MAX_INTERVALS) && cnt_b_reg <= CW'(MAX_INTERVALS))
        else $error("list count overflow");

endmodule

[hw/rtl/sorted_interval_list_intersect.sv]
// Top level of sorted_interval_list_intersect: front queue plus sweep engine.
// Depends on sili_pkg, sili_front, sili_engine.
//
//  channel | handshake      | payload
//  request | push / full    | cmd start_pos end_pos ancestry tag_a tag_b chrom
//  result  | pop / empty    | tag_a_res tag_b_res chrom_res anc_a anc_b
//          |                | overlap_start overlap_end last
//
// Loads are written to the stores as they leave the input queue. A run is taken in idle,
// then makes at most 2*MAX_INTERVALS-1 pointer steps (each a store read, then a compare),
// then flushes one or two results.
// Reset clears counts, queues and state; stores keep contents.
// A full result queue stalls the sweep; the two-entry input queue keeps filling.
module sorted_interval_list_intersect #(
    parameter int MAX_INTERVALS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic signed [31:0] start_pos,
    input  logic signed [31:0] end_pos,
    input  logic [7:0]  ancestry,
    input  logic [15:0] tag_a,
    input  logic [15:0] tag_b,
    input  logic [7:0]  chrom,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] tag_a_res,
    output logic [15:0] tag_b_res,
    output logic [7:0]  chrom_res,
    output logic signed [8:0]  anc_a,
    output logic signed [8:0]  anc_b,
    output logic signed [31:0] overlap_start,
    output logic signed [31:0] overlap_end,
    output logic        last
);

    sili_pkg::op_t  in_op, q_op;
    sili_pkg::res_t res;
    logic q_valid, q_take, res_valid;

    assign in_op.cmd       = sili_pkg::cmd_t'(cmd);
    assign in_op.start_pos = start_pos;
    assign in_op.end_pos   = end_pos;
    assign in_op.ancestry  = ancestry;
    assign in_op.tag_a     = tag_a;
    assign in_op.tag_b     = tag_b;
    assign in_op.chrom     = chrom;

    sili_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_op   (in_op),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_take  (q_take)
    );

    sili_engine #(.MAX_INTERVALS(MAX_INTERVALS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_take    (q_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop && res_valid)
    );

    assign empty         = !res_valid;
    assign tag_a_res     = res.tag_a_res;
    assign tag_b_res     = res.tag_b_res;
    assign chrom_res     = res.chrom_res;
    assign anc_a         = res.anc_a;
    assign anc_b         = res.anc_b;
    assign overlap_start = res.overlap_start;
    assign overlap_end   = res.overlap_end;
    assign last          = res.last;

endmodule

[verif/testbench.sv]
// Self-checking testbench for sorted_interval_list_intersect: loads interval
// lists, runs sweeps, and checks every result against an in-bench predictor.
// Depends on sili_pkg and the sorted_interval_list_intersect RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXN = 32;

    typedef struct {
        sili_pkg::cmd_t op;
        logic [31:0] s;
        logic [31:0] e;
        logic [7:0]  lab;
        logic [15:0] ta;
        logic [15:0] tb;
        logic [7:0]  ch;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [1:0] cmd = 2'd0;
    logic signed [31:0] start_pos = '0, end_pos = '0;
    logic [7:0] ancestry = '0, chrom = '0;
    logic [15:0] tag_a = '0, tag_b = '0;
    logic [15:0] tag_a_res, tag_b_res;
    logic [7:0] chrom_res;
    logic signed [8:0] anc_a, anc_b;
    logic signed [31:0] overlap_start, overlap_end;
    logic last;

    sorted_interval_list_intersect u_top (.*);

    always #4 clk = ~clk;

    request_t          pending[$];
    sili_pkg::res_t    expected_res[$];
    int       errors = 0;
    bit       stim_done = 0;
    bit       calm = 0;
    int       hold_off = 0;
    bit       drain_wait = 0;
    bit       in_acc = 0;

    // predictor state
    logic signed [31:0] a_s[MAXN], a_e[MAXN], b_s[MAXN], b_e[MAXN];
    logic [7:0] a_l[MAXN], b_l[MAXN];
    int na = 0, nb = 0;

    function automatic sili_pkg::res_t make_res(request_t r, logic [8:0] aa, logic [8:0] ab,
                                                logic [31:0] os, logic [31:0] oe);
        sili_pkg::res_t x;
        x.tag_a_res = r.ta; x.tag_b_res = r.tb; x.chrom_res = r.ch;
        x.anc_a = aa; x.anc_b = ab; x.overlap_start = os; x.overlap_end = oe;
        x.last = 1'b0;
        return x;
    endfunction

    task automatic predict_sweep(request_t r);
        int i, j, n;
        bit stop;
        logic signed [31:0] sa, ea, sb, eb;
        i = 0; j = 0; n = 0; stop = 0;
        case (r.op)
            sili_pkg::CMD_LOAD_A:
                if (na < MAXN)
                begin
                    a_s[na] = r.s; a_e[na] = r.e; a_l[na] = r.lab; na++;
                end
            sili_pkg::CMD_LOAD_B:
                if (nb < MAXN)
                begin
                    b_s[nb] = r.s; b_e[nb] = r.e; b_l[nb] = r.lab; nb++;
                end
            sili_pkg::CMD_RUN:
            begin
                while (!stop && i < na && j < nb)
                begin
                    sa = a_s[i]; ea = a_e[i]; sb = b_s[j]; eb = b_e[j];
                    if (sa == -1 || ea == -1 || sb == -1 || eb == -1)
                    begin
                        expected_res.push_back(make_res(r, sili_pkg::ANC_NONE,
                            sili_pkg::ANC_NONE, sili_pkg::POS_NONE, sili_pkg::POS_NONE));
                        n++; stop = 1;
                    end
                    else if (ea >= sb && eb >= sa)
                    begin
                        expected_res.push_back(make_res(r, {1'b0, a_l[i]}, {1'b0, b_l[j]},
                            sa > sb ? sa : sb, ea < eb ? ea : eb));
                        n++;
                        if (ea <= eb) i++; else j++;
                    end
                    else if (sa < sb) i++;
                    else j++;
                end
                if (n == 0)
                    expected_res.push_back(make_res(r, sili_pkg::ANC_NONE,
                        sili_pkg::ANC_NONE, sili_pkg::POS_NONE, sili_pkg::POS_NONE));
                expected_res[$].last = 1'b1;
                na = 0; nb = 0;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!push || in_acc))
        begin
            if (pending.size() > 0 && !drain_wait && (calm || $urandom_range(99) >= 29))
            begin
                request_t r;
                r = pending.pop_front();
                push <= 1'b1; cmd <= r.op; start_pos <= r.s; end_pos <= r.e;
                ancestry <= r.lab; tag_a <= r.ta; tag_b <= r.tb; chrom <= r.ch;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_acc <= push && !full;
        if (push && !full)
            predict_sweep('{sili_pkg::cmd_t'(cmd), start_pos, end_pos, ancestry,
                            tag_a, tag_b, chrom});
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && (calm || $urandom_range(99) >= 29);
    end

    // monitor
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_res.size() == 0)
            begin
                $display("%0t unexpected result", $realtime);
                errors++;
            end
            else
            begin
                sili_pkg::res_t w;
                w = expected_res.pop_front();
                if (tag_a_res !== w.tag_a_res)
                    report_mismatch("tag_a_res", 32'(tag_a_res), 32'(w.tag_a_res));
                if (tag_b_res !== w.tag_b_res)
                    report_mismatch("tag_b_res", 32'(tag_b_res), 32'(w.tag_b_res));
                if (chrom_res !== w.chrom_res)
                    report_mismatch("chrom_res", 32'(chrom_res), 32'(w.chrom_res));
                if (anc_a !== w.anc_a) report_mismatch("anc_a", 32'(anc_a), 32'(w.anc_a));
                if (anc_b !== w.anc_b) report_mismatch("anc_b", 32'(anc_b), 32'(w.anc_b));
                if (overlap_start !== w.overlap_start)
                    report_mismatch("overlap_start", overlap_start, w.overlap_start);
                if (overlap_end !== w.overlap_end)
                    report_mismatch("overlap_end", overlap_end, w.overlap_end);
                if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
            end
        end
    end

    function automatic request_t mk(sili_pkg::cmd_t op, logic [31:0] s, logic [31:0] e);
        request_t r;
        r.op = op; r.s = s; r.e = e; r.lab = 8'($urandom); r.ta = 16'($urandom);
        r.tb = 16'($urandom); r.ch = 8'($urandom);
        return r;
    endfunction

    // one well-formed sorted list pair followed by a run
    task automatic add_sweep(int la, int lb, int span);
        int k;
        int pos;
        int w;
        pos = $urandom_range(span);
        for (k = 0; k < la; k++)
        begin
            w = $urandom_range(span);
            pending.push_back(mk(sili_pkg::CMD_LOAD_A, pos, pos + w));
            pos += w + $urandom_range(span);
        end
        pos = $urandom_range(span);
        for (k = 0; k < lb; k++)
        begin
            w = $urandom_range(span);
            pending.push_back(mk(sili_pkg::CMD_LOAD_B, pos, pos + w));
            pos += w + $urandom_range(span);
        end
        pending.push_back(mk(sili_pkg::CMD_RUN, $urandom, $urandom));
    endtask

    initial
    begin
        int k;
        int t;
        request_t r;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        pending.push_back(mk(sili_pkg::CMD_NOP, 5, 9));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 32'h8000_0000, 32'h7FFF_FFFF));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 32'hFFFF_FFFE, 10));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 10, 20));
        r = mk(sili_pkg::CMD_RUN, 0, 0); r.ta = 16'hFFFF; r.tb = 16'h0000; r.ch = 8'hFF;
        pending.push_back(r);
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 0, 10));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 20, 30));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 5, 25));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 30, 30));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 32'hFFFF_FFFF, 40));
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 0, 1));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 5, 6));
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 3, 32'hFFFF_FFFF));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 0, 9));
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 4, 8));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 4, 8));
        r = mk(sili_pkg::CMD_LOAD_B, 0, 0); r.lab = 8'hFF; pending.push_back(r);
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        // overlap followed by disjoint steps up to the end of the sweep
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 0, 10));
        pending.push_back(mk(sili_pkg::CMD_LOAD_A, 20, 30));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 5, 8));
        pending.push_back(mk(sili_pkg::CMD_LOAD_B, 40, 50));
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        // full lists with ignored overflow loads
        for (k = 0; k < 33; k++)
            pending.push_back(mk(sili_pkg::CMD_LOAD_A, k * 4, k * 4 + 2));
        for (k = 0; k < 33; k++)
            pending.push_back(mk(sili_pkg::CMD_LOAD_B, k * 4 + 1, k * 4 + 5));
        pending.push_back(mk(sili_pkg::CMD_RUN, 0, 0));
        wait (pending.size() == 0);

        // receiver holds off while sender fills the block
        hold_off = 150;
        for (k = 0; k < 3; k++) add_sweep(6, 6, 8);
        wait (pending.size() == 0);
        drain_wait = 1;
        wait (expected_res.size() == 0);
        repeat (140) @(posedge clk);
        drain_wait = 0;

        // random
        t = 0;
        while (t < 160)
        begin
            calm = (t >= 60 && t < 100);
            k = $urandom_range(99);
            if (k < 75)
            begin
                add_sweep($urandom_range(5), $urandom_range(5), k < 60 ? 20 : 1 << 20);
                t += 6;
            end
            else if (k < 95)
            begin
                r = mk(sili_pkg::cmd_t'($urandom_range(3)), $urandom, $urandom);
                if ($urandom_range(3) == 0) r.s = 32'hFFFF_FFFF;
                if ($urandom_range(3) == 0) r.e = 32'hFFFF_FFFF;
                pending.push_back(r);
                t++;
            end
            else
            begin
                add_sweep(32, $urandom_range(32), 4);
                t += 30;
            end
            wait (pending.size() < 8);
        end
        wait (pending.size() == 0);
        calm = 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        wait (expected_res.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/sili_pkg.sv
hw/rtl/sili_front.sv
hw/rtl/sili_engine.sv
hw/rtl/sorted_interval_list_intersect.sv
verif/testbench.sv
